// ===== src/lbsd_pkg.sv =====
`default_nettype none

package lbsd_pkg;

    // Default build sizes
    localparam int LED_BITS_DEF   = 8;
    localparam int NUM_DIGITS_DEF = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_STACK_STEP_TICKS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_TICKS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCANS_PER_COUNT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_FROM       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_TO         = 3'd4;

    // Register reset values
    localparam logic [15:0] STACK_STEP_TICKS_RST = 16'd200;
    localparam logic [7:0]  DIGIT_TICKS_RST      = 8'd2;
    localparam logic [7:0]  SCANS_PER_COUNT_RST  = 8'd125;
    localparam logic [13:0] COUNT_FROM_RST       = 14'd0;
    localparam logic [13:0] COUNT_TO_RST         = 14'd9;

    localparam logic [13:0] COUNT_MAX = 14'd9999;
    localparam logic [7:0]  SEG_BLANK = 8'hFF;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'b001,
        MODE_STACK = 3'b010,
        MODE_COUNT = 3'b100
    } mode_t;

    function automatic logic [13:0] clamp_count(input logic [13:0] v);
        return (v > COUNT_MAX) ? COUNT_MAX : v;
    endfunction

    // Reciprocal multiplies, exact for any value up to COUNT_MAX
    function automatic logic [13:0] div10(input logic [13:0] v);
        logic [31:0] p;
        p = 32'(v) * 32'd52429;
        return 14'(p >> 19);
    endfunction

    function automatic logic [13:0] div100(input logic [13:0] v);
        logic [31:0] p;
        p = 32'(v) * 32'd5243;
        return 14'(p >> 19);
    endfunction

    function automatic logic [13:0] div1000(input logic [13:0] v);
        logic [31:0] p;
        p = 32'(v) * 32'd8389;
        return 14'(p >> 23);
    endfunction

    // Active-low font, segment a in bit 0, decimal point in bit 7
    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/led_bar_and_seven_segment_mode_driver.sv =====
`default_nettype none

// Mode driver for an LED bar and a multiplexed active-low seven-segment
// display. Each input word is one 1 ms tick carrying three event flags; off
// beats count and count beats stack, and an event for the mode already
// running is ignored. Stack mode runs a light along the bar that piles up at
// the far end, restarting from an empty bar once the bar is full. Count mode
// scans the digits (digit_enable bit 0 is the most significant digit) and
// steps the shown number from count_from toward count_to, then reloads
// count_from; equal bounds blank the display. Every tick gives exactly one
// output word: the pins as they stand during that tick. One word is taken
// per clock while out_stall does not hold the output: all timers, counters
// and the digit decode settle in one pass from the state registers into the
// output register, and a new word is taken in the same cycle the previous
// result is taken. Configuration writes via cfg_write are registered.
module led_bar_and_seven_segment_mode_driver
    import lbsd_pkg::*;
#(
    parameter int LED_BITS   = LED_BITS_DEF,
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic                   press_stack,
    input  wire logic                   irq_count,
    input  wire logic                   irq_off,

    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      logic [LED_BITS-1:0]    led_bar,
    output      logic [7:0]             segments,
    output      logic [NUM_DIGITS-1:0]  digit_enable
);

    localparam int POS_W  = $clog2(LED_BITS);
    localparam int RUN_W  = $clog2(LED_BITS + 1);
    localparam int SCAN_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // Configuration registers
    logic [15:0] stack_step_ticks_reg;
    logic [7:0]  digit_ticks_reg;
    logic [7:0]  scans_per_count_reg;
    logic [13:0] count_from_reg;
    logic [13:0] count_to_reg;

    // Mode and sequence state
    mode_t               mode_reg, mode_next;
    logic [LED_BITS-1:0] stack_fixed_reg, stack_fixed_next;
    logic [LED_BITS-1:0] stack_moving_reg, stack_moving_next;
    logic [RUN_W-1:0]    stack_run_length_reg, stack_run_length_next;
    logic [POS_W-1:0]    stack_position_reg, stack_position_next;
    logic [15:0]         step_timer_reg, step_timer_next;
    logic [13:0]         count_value_reg, count_value_next;
    logic [SCAN_W-1:0]   scan_digit_reg, scan_digit_next;
    logic [7:0]          digit_timer_reg, digit_timer_next;
    logic [7:0]          scan_counter_reg, scan_counter_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [LED_BITS-1:0]   led_bar_reg, led_bar_next;
    logic [7:0]            segments_reg, segments_next;
    logic [NUM_DIGITS-1:0] digit_enable_reg, digit_enable_next;

    // Working values: state after a possible mode entry, before the advance
    mode_t               want;
    logic                in_accept;
    logic [LED_BITS-1:0] fixed_c, moving_c;
    logic [RUN_W-1:0]    run_c, run_dec;
    logic [POS_W-1:0]    pos_c;
    logic [RUN_W:0]      pos_inc;
    logic [15:0]         stimer_c;
    logic [16:0]         stimer_inc, step_lim;
    logic [13:0]         cval_c;
    logic [SCAN_W-1:0]   sdig_c;
    logic [SCAN_W:0]     sdig_inc;
    logic [7:0]          dtimer_c, scnt_c;
    logic [8:0]          dtimer_inc, digit_lim, scnt_inc, scan_lim;
    logic [13:0]         from_cl, to_cl;

    // Digit decode
    logic [13:0]       shown, q1, q2, q3;
    logic [13:0]       d0_w, d1_w, d2_w;
    logic [SCAN_W-1:0] place;
    logic [2:0]        place3;
    logic [3:0]        digit;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign led_bar      = led_bar_reg;
    assign segments     = segments_reg;
    assign digit_enable = digit_enable_reg;

    assign from_cl = clamp_count(count_from_reg);
    assign to_cl   = clamp_count(count_to_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_step_ticks_reg <= STACK_STEP_TICKS_RST;
            digit_ticks_reg      <= DIGIT_TICKS_RST;
            scans_per_count_reg  <= SCANS_PER_COUNT_RST;
            count_from_reg       <= COUNT_FROM_RST;
            count_to_reg         <= COUNT_TO_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STACK_STEP_TICKS: stack_step_ticks_reg <= cfg_data;
                CFG_DIGIT_TICKS:      digit_ticks_reg      <= cfg_data[7:0];
                CFG_SCANS_PER_COUNT:  scans_per_count_reg  <= cfg_data[7:0];
                CFG_COUNT_FROM:       count_from_reg       <= cfg_data[13:0];
                CFG_COUNT_TO:         count_to_reg         <= cfg_data[13:0];
                default:              ;
            endcase
        end
    end

    // Event priority: off, then count, then stack; no flag keeps the mode
    always_comb
    begin
        want = mode_reg;
        if (irq_off)
            want = MODE_OFF;
        else if (irq_count)
            want = MODE_COUNT;
        else if (press_stack)
            want = MODE_STACK;
    end

    // Entering a new mode restarts its sequence on the same tick
    always_comb
    begin
        fixed_c  = stack_fixed_reg;
        moving_c = stack_moving_reg;
        run_c    = stack_run_length_reg;
        pos_c    = stack_position_reg;
        stimer_c = step_timer_reg;
        cval_c   = count_value_reg;
        sdig_c   = scan_digit_reg;
        dtimer_c = digit_timer_reg;
        scnt_c   = scan_counter_reg;
        if (want != mode_reg && want == MODE_STACK)
        begin
            fixed_c  = '0;
            moving_c = LED_BITS'(1);
            run_c    = RUN_W'(LED_BITS);
            pos_c    = '0;
            stimer_c = '0;
        end
        if (want != mode_reg && want == MODE_COUNT)
        begin
            cval_c   = from_cl;
            sdig_c   = '0;
            dtimer_c = '0;
            scnt_c   = '0;
        end
    end

    // Decimal digit for the scanned position. Each place is a reciprocal
    // multiply of the shown value, all in parallel, then one select.
    assign shown  = clamp_count(cval_c);
    assign q1     = div10(shown);
    assign q2     = div100(shown);
    assign q3     = div1000(shown);
    assign d0_w   = shown - ((q1 << 3) + (q1 << 1));
    assign d1_w   = q1 - ((q2 << 3) + (q2 << 1));
    assign d2_w   = q2 - ((q3 << 3) + (q3 << 1));
    assign place  = SCAN_W'(NUM_DIGITS - 1) - sdig_c;
    assign place3 = 3'(place);

    always_comb
    begin
        case (place3)
            3'd0:    digit = d0_w[3:0];
            3'd1:    digit = d1_w[3:0];
            3'd2:    digit = d2_w[3:0];
            3'd3:    digit = q3[3:0];
            default: digit = 4'd0;
        endcase
    end

    // Timer arithmetic; a zero limit register acts as one
    assign stimer_inc = {1'b0, stimer_c} + 17'd1;
    assign step_lim   = (stack_step_ticks_reg == '0) ? 17'd1 : {1'b0, stack_step_ticks_reg};
    assign pos_inc    = (RUN_W + 1)'(pos_c) + (RUN_W + 1)'(1);
    assign run_dec    = (run_c != '0) ? run_c - RUN_W'(1) : run_c;
    assign dtimer_inc = {1'b0, dtimer_c} + 9'd1;
    assign digit_lim  = (digit_ticks_reg == '0) ? 9'd1 : {1'b0, digit_ticks_reg};
    assign sdig_inc   = {1'b0, sdig_c} + (SCAN_W + 1)'(1);
    assign scnt_inc   = {1'b0, scnt_c} + 9'd1;
    assign scan_lim   = (scans_per_count_reg == '0) ? 9'd1 : {1'b0, scans_per_count_reg};

    // Display word for this tick and the advance of the active sequence
    always_comb
    begin
        mode_next             = mode_reg;
        stack_fixed_next      = stack_fixed_reg;
        stack_moving_next     = stack_moving_reg;
        stack_run_length_next = stack_run_length_reg;
        stack_position_next   = stack_position_reg;
        step_timer_next       = step_timer_reg;
        count_value_next      = count_value_reg;
        scan_digit_next       = scan_digit_reg;
        digit_timer_next      = digit_timer_reg;
        scan_counter_next     = scan_counter_reg;
        led_bar_next          = led_bar_reg;
        segments_next         = segments_reg;
        digit_enable_next     = digit_enable_reg;
        out_valid_next        = out_valid_reg && out_stall;

        if (in_accept)
        begin
            out_valid_next        = 1'b1;
            mode_next             = want;
            stack_fixed_next      = fixed_c;
            stack_moving_next     = moving_c;
            stack_run_length_next = run_c;
            stack_position_next   = pos_c;
            step_timer_next       = stimer_c;
            count_value_next      = cval_c;
            scan_digit_next       = sdig_c;
            digit_timer_next      = dtimer_c;
            scan_counter_next     = scnt_c;
            led_bar_next          = '0;
            segments_next         = SEG_BLANK;
            digit_enable_next     = '1;

            if (want == MODE_STACK)
            begin
                led_bar_next = fixed_c | moving_c;
                if (stimer_inc < step_lim)
                begin
                    step_timer_next = stimer_inc[15:0];
                end
                else
                begin
                    step_timer_next = '0;
                    if (pos_inc >= (RUN_W + 1)'(run_c))
                    begin
                        // Light reached the pile: fix it and shorten the run, or restart when used up
                        if (run_dec == '0)
                        begin
                            stack_fixed_next      = '0;
                            stack_moving_next     = LED_BITS'(1);
                            stack_run_length_next = RUN_W'(LED_BITS);
                        end
                        else
                        begin
                            stack_fixed_next      = fixed_c | moving_c;
                            stack_moving_next     = LED_BITS'(1);
                            stack_run_length_next = run_dec;
                        end
                        stack_position_next = '0;
                    end
                    else
                    begin
                        stack_position_next = pos_inc[POS_W-1:0];
                        stack_moving_next   = LED_BITS'(1) << pos_inc[POS_W-1:0];
                    end
                end
            end
            else if (want == MODE_COUNT && from_cl != to_cl)
            begin
                segments_next     = seg_font(digit);
                digit_enable_next = ~(NUM_DIGITS'(1) << sdig_c);
                if (dtimer_inc < digit_lim)
                begin
                    digit_timer_next = dtimer_inc[7:0];
                end
                else
                begin
                    digit_timer_next = '0;
                    if (sdig_inc < (SCAN_W + 1)'(NUM_DIGITS))
                    begin
                        scan_digit_next = sdig_inc[SCAN_W-1:0];
                    end
                    else
                    begin
                        scan_digit_next = '0;
                        if (scnt_inc < scan_lim)
                        begin
                            scan_counter_next = scnt_inc[7:0];
                        end
                        else
                        begin
                            // Step the count; reaching the far bound reloads
                            scan_counter_next = '0;
                            if (from_cl < to_cl)
                                count_value_next = (cval_c >= to_cl) ? from_cl
                                                                     : cval_c + 14'd1;
                            else
                                count_value_next = (cval_c <= to_cl) ? from_cl
                                                                     : cval_c - 14'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg             <= MODE_OFF;
            stack_fixed_reg      <= '0;
            stack_moving_reg     <= LED_BITS'(1);
            stack_run_length_reg <= RUN_W'(LED_BITS);
            stack_position_reg   <= '0;
            step_timer_reg       <= '0;
            count_value_reg      <= '0;
            scan_digit_reg       <= '0;
            digit_timer_reg      <= '0;
            scan_counter_reg     <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            mode_reg             <= mode_next;
            stack_fixed_reg      <= stack_fixed_next;
            stack_moving_reg     <= stack_moving_next;
            stack_run_length_reg <= stack_run_length_next;
            stack_position_reg   <= stack_position_next;
            step_timer_reg       <= step_timer_next;
            count_value_reg      <= count_value_next;
            scan_digit_reg       <= scan_digit_next;
            digit_timer_reg      <= digit_timer_next;
            scan_counter_reg     <= scan_counter_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // Output word payload: hold while stalled
    always_ff @(posedge clk)
    begin
        led_bar_reg      <= led_bar_next;
        segments_reg     <= segments_next;
        digit_enable_reg <= digit_enable_next;
    end

`ifndef SYNTHESIS
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output word pending");

    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted word produced no output word");

    a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && led_bar != '0) |-> (segments == SEG_BLANK && digit_enable == '1))
        else $error("LED bar and digits lit in the same word");

    a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones(~digit_enable) <= 1)
        else $error("more than one digit enabled");

    a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (RUN_W + 1)'(stack_position_reg) < (RUN_W + 1)'(stack_run_length_reg))
        else $error("stack position beyond run length");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_value_reg <= COUNT_MAX)
        else $error("count value out of range");
`endif

endmodule

`default_nettype wire
